### sv/smf_pkg.sv
// shared types and constants for the sliding median filter
package smf_pkg;

    // fixed field widths of the stream items
    localparam int RANGE_BITS = 16;
    localparam int CFG_BITS   = 3;
    localparam int POS_BITS   = 16;
    // index field wide enough for a half width up to 31
    localparam int IDX_BITS   = 5;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // one input item
    typedef struct packed {
        logic [RANGE_BITS-1:0] range_sample;
        logic                  last_in_scan;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [RANGE_BITS-1:0] filtered_range;
        logic                  is_edge;
        logic                  last_of_scan;
    } t_out_item;

    // result job: median or edge tap, then optional flush down to the newest tap
    typedef struct packed {
        logic                med;
        logic                flush;
        logic [IDX_BITS-1:0] idx;
    } t_job;

endpackage

### sv/smf_cell.sv
// one window cell: holds a sample and its rank within the window
module smf_cell #(
    parameter int SW = 16,
    parameter int RW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic [SW-1:0] i_val,
    input  logic [RW-1:0] i_rank,
    input  logic [SW-1:0] i_new,
    input  logic [SW-1:0] i_leave,
    output logic [SW-1:0] o_val,
    output logic [RW-1:0] o_rank,
    output logic [RW-1:0] o_rank_fwd,
    output logic          o_le
);

    logic [SW-1:0] r_val;
    logic [RW-1:0] r_rank;
    logic          new_lt;
    logic          leave_le;

    // the incoming sample is younger, so it ranks below only when strictly smaller;
    // the leaving sample is the oldest, so it ranks below on a tie too
    assign new_lt     = (i_new < r_val);
    assign leave_le   = (i_leave <= r_val);
    assign o_le       = (r_val <= i_new);
    assign o_rank_fwd = r_rank + RW'(new_lt) - RW'(leave_le);
    assign o_val      = r_val;
    assign o_rank     = r_rank;

    // take the left neighbor's sample and updated rank on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_rank <= '0;
        end else if (i_shift) begin
            r_val  <= i_val;
            r_rank <= i_rank;
        end
    end

endmodule

### sv/smf_emit.sv
// result sequencer and output register: one result item per cycle while the output is not stalled
module smf_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_job_vld,
    input  smf_pkg::t_job              i_job,
    input  logic [smf_pkg::RANGE_BITS-1:0] i_value,
    output smf_pkg::t_job              o_job,
    output logic                       o_busy,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output smf_pkg::t_out_item         o_out_item
);
    import smf_pkg::*;

    logic      r_vld;
    t_job      r_job;
    logic      r_out_vld;
    t_out_item r_out;
    logic      n_vld;
    t_job      n_job;
    logic      adv;
    logic      fire;
    logic      fin;
    t_out_item item;

    // output register free or being drained
    assign adv  = !r_out_vld || !i_out_stall;
    assign fire = r_vld && adv;
    assign fin  = !r_job.flush || (r_job.idx == '0);

    assign o_busy = r_vld && !(fire && fin);
    assign o_job  = r_job;

    // result built from the current job
    always_comb begin
        item.filtered_range = i_value;
        item.is_edge        = !r_job.med;
        item.last_of_scan   = r_job.flush && (r_job.idx == '0);
    end

    // job sequencing: load on accept, otherwise step down the flush until the job is done
    always_comb begin
        n_vld = r_vld;
        n_job = r_job;
        if (i_accept) begin
            n_vld = i_job_vld;
            n_job = i_job;
        end else if (fire) begin
            if (fin) begin
                n_vld = 1'b0;
            end else begin
                n_job.med = 1'b0;
                n_job.idx = r_job.idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (fire) begin
            r_out <= item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

### sv/sliding_median_filter.sv
// sliding median filter top level: cell chain, scan control and result sequencer
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  in      | i_in_valid/o_in_stall | i_in_item  (range, last flag)
//  out     | o_out_valid/i_out_stall | o_out_item (range, edge, last)
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_data (half width k)
//
// an item enters every cycle while the input is not stalled; its result leaves through
// the result sequencer's job register and the output register, which read the cell chain
// the last item of a scan stalls the input while the sequencer flushes the pending
// samples (up to k, at most MAX_HALF) one per cycle while the output is not stalled
// reset clears the cells, scan position and half width (k = 1)
// a stall on the output holds the sequencer and then the input
module sliding_median_filter #(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  smf_pkg::t_in_item       i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output smf_pkg::t_out_item      o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [smf_pkg::CFG_BITS-1:0] i_cfg_data
);
    import smf_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int RW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_HALF + 1);
    localparam int SW    = SAMPLE_BITS;

    logic [CFG_BITS-1:0] r_cfg;
    logic [KW-1:0]       r_active;
    logic [POS_BITS-1:0] r_pos;

    logic                acc;
    logic [SW-1:0]       sample;
    logic [SW+RANGE_BITS-1:0] sample_ext;
    logic [KW-1:0]       k_cfg;
    logic [KW-1:0]       k_eff;
    logic [RW-1:0]       lidx;
    logic [SW-1:0]       leave_val;
    logic [RW-1:0]       new_rank;
    logic [POS_BITS-1:0] k_pos;
    logic [POS_BITS-1:0] k2_pos;
    logic                job_vld;
    t_job                job;
    t_job                cur;
    logic                busy;
    logic [SW-1:0]       med_val;
    logic [SW-1:0]       sel_val;
    logic [RANGE_BITS+SW-1:0] out_ext;
    logic [RANGE_BITS-1:0] value;

    logic [SW-1:0] cell_val   [DEPTH];
    logic [RW-1:0] cell_rank  [DEPTH];
    logic [RW-1:0] cell_fwd   [DEPTH];
    logic          cell_le    [DEPTH];

    assign o_cfg_ready = 1'b1;
    assign acc         = i_in_valid && !o_in_stall;
    assign o_in_stall  = busy;

    // keep the low sample bits of the range field
    assign sample_ext = {{SW{1'b0}}, i_in_item.range_sample};
    assign sample     = sample_ext[SW-1:0];

    // clamp the register to 1..MAX_HALF
    always_comb begin
        if (r_cfg == '0) begin
            k_cfg = KW'(1);
        end else if (int'(r_cfg) > MAX_HALF) begin
            k_cfg = KW'(MAX_HALF);
        end else begin
            k_cfg = KW'(r_cfg);
        end
    end

    // half width latched at the first item of a scan
    assign k_eff  = (r_pos == '0) ? k_cfg : r_active;
    assign lidx   = RW'({k_eff, 1'b0});
    assign k_pos  = POS_BITS'(k_eff);
    assign k2_pos = POS_BITS'({k_eff, 1'b0});

    // sample leaving the window and the rank of the incoming one
    always_comb begin
        leave_val = cell_val[lidx];
        new_rank  = '0;
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (i < int'(lidx)) begin
                new_rank = new_rank + RW'(cell_le[i]);
            end
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        smf_cell #(
            .SW(SW),
            .RW(RW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (acc),
            .i_val      ((g == 0) ? sample : cell_val[(g == 0) ? 0 : g - 1]),
            .i_rank     ((g == 0) ? new_rank : cell_fwd[(g == 0) ? 0 : g - 1]),
            .i_new      (sample),
            .i_leave    (leave_val),
            .o_val      (cell_val[g]),
            .o_rank     (cell_rank[g]),
            .o_rank_fwd (cell_fwd[g]),
            .o_le       (cell_le[g])
        );
    end

    // result job for the accepted item
    always_comb begin
        job_vld   = (r_pos >= k_pos) || i_in_item.last_in_scan;
        job.flush = i_in_item.last_in_scan;
        if (r_pos >= k_pos) begin
            job.idx = IDX_BITS'(k_eff);
            job.med = !(r_pos < k2_pos);
        end else begin
            job.idx = r_pos[IDX_BITS-1:0];
            job.med = 1'b0;
        end
    end

    // scan control and register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_BITS'(1);
            r_active <= KW'(1);
            r_pos    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (acc) begin
                r_active <= k_eff;
                if (i_in_item.last_in_scan) begin
                    r_pos <= '0;
                end else if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // median: the cell whose rank equals k inside the window
    always_comb begin
        med_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i <= 2 * int'(r_active) && cell_rank[i] == RW'(r_active)) begin
                med_val = med_val | cell_val[i];
            end
        end
    end

    // value of the current result
    assign sel_val = cur.med ? med_val : cell_val[RW'(cur.idx)];
    assign out_ext = {{RANGE_BITS{1'b0}}, sel_val};
    assign value   = out_ext[RANGE_BITS-1:0];

    smf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (acc),
        .i_job_vld   (job_vld),
        .i_job       (job),
        .i_value     (value),
        .o_job       (cur),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // a median result never closes a scan
    a_last_is_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.last_of_scan || o_out_item.is_edge))
        else $error("last result of a scan not flagged edge");

    // a last item restarts the scan position
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_item.last_in_scan) |=> (r_pos == '0))
        else $error("scan position not cleared after last item");

    // active half width stays in range
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != '0) && (int'(r_active) <= MAX_HALF))
        else $error("active half width out of range");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for the sliding median filter: predicts medians, edges and scan flushes
module testbench;
    import smf_pkg::*;

    localparam int MAX_HALF      = 7;
    localparam int WIN_DEPTH     = 2 * MAX_HALF + 1;
    // output register path plus the longest flush of a last item
    localparam int SETTLE_CYCLES = 2 * MAX_HALF + 6;

    logic                i_clk       = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data;

    // predictor state
    logic [CFG_BITS-1:0]   half_setting;
    logic [RANGE_BITS-1:0] sample_window [WIN_DEPTH];
    logic [POS_BITS-1:0]   scan_count;
    int                    scan_half;
    t_out_item             expected_filtered_q [$];

    logic [RANGE_BITS-1:0] prev_sample   = '0;
    int                    mismatch_count = 0;
    int                    send_idle_pct  = 0;
    int                    stall_pct      = 0;

    sliding_median_filter #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (RANGE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // half width as used by a scan: zero acts as one
    function automatic int effective_half(logic [CFG_BITS-1:0] value);
        if (value == '0) return 1;
        if (int'(value) > MAX_HALF) return MAX_HALF;
        return int'(value);
    endfunction

    // median of the 2k+1 newest samples
    function automatic logic [RANGE_BITS-1:0] window_median(int k);
        logic [RANGE_BITS-1:0] sorted [WIN_DEPTH];
        logic [RANGE_BITS-1:0] value;
        int                    j;
        for (int i = 0; i < 2 * k + 1; i++) begin
            value = sample_window[i];
            j = i;
            while (j > 0 && sorted[j-1] > value) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = value;
        end
        return sorted[k];
    endfunction

    // advance the filter by one accepted item and queue the results it releases
    function automatic void predict_scan_step(t_in_item item);
        int k;
        int p;
        if (scan_count == '0) scan_half = effective_half(half_setting);
        k = scan_half;
        p = scan_count;
        for (int i = WIN_DEPTH - 1; i > 0; i--) sample_window[i] = sample_window[i-1];
        sample_window[0] = item.range_sample;
        // delayed sample: edge near the scan start, median otherwise
        if (p >= k) begin
            if (p < 2 * k)
                expected_filtered_q.push_back(t_out_item'{sample_window[k], 1'b1, 1'b0});
            else
                expected_filtered_q.push_back(t_out_item'{window_median(k), 1'b0, 1'b0});
        end
        // flush of the pending samples, oldest first
        if (item.last_in_scan) begin
            for (int i = (p >= k) ? k - 1 : p; i >= 0; i--)
                expected_filtered_q.push_back(t_out_item'{sample_window[i], 1'b1, i == 0});
        end
        if (item.last_in_scan) scan_count = '0;
        else if (scan_count != POS_MAX) scan_count++;
    endfunction

    function automatic void report_field(string field, logic [RANGE_BITS-1:0] want,
                                         logic [RANGE_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_filtered_q.size() == 0) begin
                $display("%0t ns: result expected none actual %h", $time, o_out_item);
                mismatch_count++;
            end else begin
                want = expected_filtered_q.pop_front();
                report_field("filtered_range", want.filtered_range, o_out_item.filtered_range);
                report_field("is_edge", RANGE_BITS'(want.is_edge),
                             RANGE_BITS'(o_out_item.is_edge));
                report_field("last_of_scan", RANGE_BITS'(want.last_of_scan),
                             RANGE_BITS'(o_out_item.last_of_scan));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // random sample with extremes and repeats for ties
    function automatic logic [RANGE_BITS-1:0] pick_sample();
        logic [RANGE_BITS-1:0] value;
        case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            2:       value = prev_sample;
            default: value = RANGE_BITS'($urandom);
        endcase
        prev_sample = value;
        return value;
    endfunction

    // send one item; valid stays high until the next item or an idle gap
    task automatic send_sample(input logic [RANGE_BITS-1:0] value, input bit last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= t_in_item'{value, last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_scan_step(i_in_item);
    endtask

    task automatic send_scan(input int len);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    endtask

    // wait until every expected result is out and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half(input logic [CFG_BITS-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        half_setting = value;
        i_cfg_valid <= 1'b0;
    endtask

    // half width 1 from reset, extremes of the range
    task automatic test_default_half();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h1234, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_idle();
    endtask

    task automatic test_one_sample_scan();
        send_sample(16'ha5a5, 1'b1);
        wait_idle();
    endtask

    // a written zero acts as half width 1
    task automatic test_half_zero();
        write_half('0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b1);
        wait_idle();
    endtask

    // widest window, long enough for two full medians
    task automatic test_max_half();
        logic [RANGE_BITS-1:0] value;
        write_half(CFG_BITS'(MAX_HALF));
        for (int i = 0; i < 2 * MAX_HALF + 2; i++) begin
            value = (i % 2 == 1) ? RANGE_BITS'(i * 977) : 16'hffff - RANGE_BITS'(i * 311);
            send_sample(value, i == 2 * MAX_HALF + 1);
        end
        wait_idle();
    endtask

    // new half width only applies from the next scan, which is shorter than its window
    task automatic test_mid_scan_write();
        write_half(3'd2);
        send_sample(16'h0100, 1'b0);
        send_sample(16'hff00, 1'b0);
        send_sample(16'h0001, 1'b0);
        write_half(3'd5);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h00ff, 1'b1);
        send_scan(4);
        wait_idle();
    endtask

    // random scans, mostly at least as long as the window, with half width changes between scans
    task automatic run_random_phase(input int send_pct, input int stall_in, input int n_items);
        int sent;
        int k;
        int len;
        send_idle_pct = send_pct;
        stall_pct     = stall_in;
        sent          = 0;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) write_half(CFG_BITS'($urandom_range(7)));
            k = effective_half(half_setting);
            if ($urandom_range(9) < 8) len = $urandom_range(2 * k + 1, 4 * k + 4);
            else len = $urandom_range(1, 2 * k);
            send_scan(len);
            sent += len;
        end
        wait_idle();
    endtask

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        half_setting = 3'd1;
        for (int i = 0; i < WIN_DEPTH; i++) sample_window[i] = '0;
        scan_count = '0;
        scan_half  = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_half();
        test_one_sample_scan();
        test_half_zero();
        test_max_half();
        test_mid_scan_write();

        run_random_phase(0, 0, 15);
        run_random_phase(77, 0, 15);
        run_random_phase(0, 77, 15);
        run_random_phase(38, 38, 15);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
